[rtl/bq_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Biquad shared package
// Widths, register indexes, controller states, command and status bundles,
// and the rounding and clamping helpers of the datapath.
// ============================================================================
package bq_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int STATE_W    = 32;
    localparam int FRAC_SHIFT = 20;
    localparam int PROD_W     = COEF_W + STATE_W;       // 56
    localparam int ACC_W      = PROD_W + 2;             // 58, three terms
    localparam int RND_W      = ACC_W - FRAC_SHIFT;     // 38
    localparam int IDX_W      = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_A1 = 3'd0,
        REG_A2 = 3'd1,
        REG_B0 = 3'd2,
        REG_B1 = 3'd3,
        REG_B2 = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A1,
        ST_A2,
        ST_WADD,
        ST_WRND,
        ST_B2,
        ST_B0,
        ST_YADD,
        ST_YRND
    } state_t;

    typedef enum logic [2:0] {
        MUL_A1W1,
        MUL_A2W2,
        MUL_B1W1,
        MUL_B2W2,
        MUL_B0W
    } mul_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     load_x;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_add;
        logic     acc_clear;
        logic     w_latch;
        logic     commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } ctrl_status_t;

    // Round half up: add half an LSB, then floor-shift by FRAC_SHIFT.
    function automatic logic signed [RND_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W-1:0] t;
        t = a + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
        return t[ACC_W-1:FRAC_SHIFT];
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [RND_W-1:0] v
    );
        logic [RND_W-STATE_W:0] top;
        top = v[RND_W-1:STATE_W-1];
        if (top == '0 || top == '1)
            return v[STATE_W-1:0];
        else if (v[RND_W-1])
            return {1'b1, {(STATE_W-1){1'b0}}};
        else
            return {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [RND_W-1:0] v
    );
        logic [RND_W-SAMPLE_W:0] top;
        top = v[RND_W-1:SAMPLE_W-1];
        if (top == '0 || top == '1)
            return v[SAMPLE_W-1:0];
        else if (v[RND_W-1])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

[rtl/bq_in_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// Biquad input sample channel
// Valid/ready channel carrying one input sample per request.
// ============================================================================
interface bq_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bq_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

[rtl/bq_out_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// Biquad output sample channel
// Valid/ready channel carrying one filtered sample per request.
// ============================================================================
interface bq_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bq_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/bq_cfg_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// Biquad coefficient write channel
// Valid/ready channel carrying a register index and write data.
// ============================================================================
interface bq_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bq_pkg::IDX_W-1:0]          index;
    logic [bq_pkg::COEF_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bq_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// Biquad datapath
// Coefficient registers, delay pair, shared multiplier with product register,
// accumulator, rounding/clamping and the output register.
// ============================================================================
module bq_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bq_pkg::ctrl_cmd_t     cmd,
    output bq_pkg::ctrl_status_t  status,
    bq_in_if.sink                 din,
    bq_out_if.source              dout,
    bq_cfg_if.sink                cfg
);

    logic signed [bq_pkg::COEF_W-1:0]   a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;
    logic signed [bq_pkg::STATE_W-1:0]  delay_one_reg, delay_two_reg;
    logic signed [bq_pkg::STATE_W-1:0]  w_reg, w_next;
    logic signed [bq_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [bq_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [bq_pkg::SAMPLE_W-1:0] out_reg, y_next;
    logic                               out_valid_reg;
    logic signed [bq_pkg::COEF_W-1:0]   mul_coef;
    logic signed [bq_pkg::STATE_W-1:0]  mul_state;
    logic signed [bq_pkg::ACC_W-1:0]    x_ext;
    logic signed [bq_pkg::ACC_W-1:0]    prod_ext;

    assign cfg.ready       = 1'b1;
    assign din.ready       = cmd.in_ready;
    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_reg;

    assign status.in_valid = din.valid;
    assign status.out_free = !out_valid_reg || dout.ready;

    // Coefficient writes; indexes past the list drop silently.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg <= '0;
            a2_reg <= '0;
            b0_reg <= '0;
            b1_reg <= '0;
            b2_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (bq_pkg::reg_idx_t'(cfg.index))
                bq_pkg::REG_A1: a1_reg <= cfg.data;
                bq_pkg::REG_A2: a2_reg <= cfg.data;
                bq_pkg::REG_B0: b0_reg <= cfg.data;
                bq_pkg::REG_B1: b1_reg <= cfg.data;
                bq_pkg::REG_B2: b2_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            bq_pkg::MUL_A1W1:
            begin
                mul_coef  = a1_reg;
                mul_state = delay_one_reg;
            end
            bq_pkg::MUL_A2W2:
            begin
                mul_coef  = a2_reg;
                mul_state = delay_two_reg;
            end
            bq_pkg::MUL_B1W1:
            begin
                mul_coef  = b1_reg;
                mul_state = delay_one_reg;
            end
            bq_pkg::MUL_B2W2:
            begin
                mul_coef  = b2_reg;
                mul_state = delay_two_reg;
            end
            bq_pkg::MUL_B0W:
            begin
                mul_coef  = b0_reg;
                mul_state = w_reg;
            end
            default:
            begin
                mul_coef  = '0;
                mul_state = '0;
            end
        endcase
    end

    assign prod_next = mul_coef * mul_state;

    assign x_ext = {{(bq_pkg::ACC_W - bq_pkg::SAMPLE_W - bq_pkg::FRAC_SHIFT)
                     {din.sample_in[bq_pkg::SAMPLE_W-1]}},
                    din.sample_in, {bq_pkg::FRAC_SHIFT{1'b0}}};
    assign prod_ext = {{(bq_pkg::ACC_W - bq_pkg::PROD_W){prod_reg[bq_pkg::PROD_W-1]}},
                       prod_reg};

    always_comb
    begin
        if (cmd.load_x)
            acc_next = x_ext;
        else if (cmd.acc_clear)
            acc_next = '0;
        else if (cmd.acc_add)
            acc_next = acc_reg + prod_ext;
        else
            acc_next = acc_reg;
    end

    assign w_next = bq_pkg::sat_state(bq_pkg::round_shift(acc_reg));
    assign y_next = bq_pkg::sat_sample(bq_pkg::round_shift(acc_reg));

    // Working registers: no reset, the controller sequences every use.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (cmd.w_latch)
            w_reg <= w_next;
        if (cmd.commit)
            out_reg <= y_next;
    end

    // Delay pair shifts only when the result is committed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                delay_two_reg <= delay_one_reg;
                delay_one_reg <= w_reg;
            end
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && delay_one_reg == $past(w_reg)
                       && delay_two_reg == $past(delay_one_reg))
        else $error("commit did not shift delay pair or raise output");

endmodule

[rtl/bq_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// Biquad controller
// Sequences the five products and two roundings of one sample.
// ============================================================================
module bq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bq_pkg::ctrl_status_t  status,
    output bq_pkg::ctrl_cmd_t     cmd
);

    bq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bq_pkg::ST_IDLE: if (status.in_valid) state_next = bq_pkg::ST_A1;
            bq_pkg::ST_A1:   state_next = bq_pkg::ST_A2;
            bq_pkg::ST_A2:   state_next = bq_pkg::ST_WADD;
            bq_pkg::ST_WADD: state_next = bq_pkg::ST_WRND;
            bq_pkg::ST_WRND: state_next = bq_pkg::ST_B2;
            bq_pkg::ST_B2:   state_next = bq_pkg::ST_B0;
            bq_pkg::ST_B0:   state_next = bq_pkg::ST_YADD;
            bq_pkg::ST_YADD: state_next = bq_pkg::ST_YRND;
            bq_pkg::ST_YRND: if (status.out_free) state_next = bq_pkg::ST_IDLE;
            default:         state_next = bq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = bq_pkg::MUL_A1W1;
        case (state_reg)
            bq_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load_x   = status.in_valid;
            end
            bq_pkg::ST_A1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bq_pkg::MUL_A1W1;
            end
            bq_pkg::ST_A2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bq_pkg::MUL_A2W2;
                cmd.acc_add = 1'b1;
            end
            bq_pkg::ST_WADD:
            begin
                cmd.acc_add = 1'b1;
            end
            bq_pkg::ST_WRND:
            begin
                cmd.w_latch   = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = bq_pkg::MUL_B1W1;
                cmd.acc_clear = 1'b1;
            end
            bq_pkg::ST_B2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bq_pkg::MUL_B2W2;
                cmd.acc_add = 1'b1;
            end
            bq_pkg::ST_B0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bq_pkg::MUL_B0W;
                cmd.acc_add = 1'b1;
            end
            bq_pkg::ST_YADD:
            begin
                cmd.acc_add = 1'b1;
            end
            bq_pkg::ST_YRND:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_x |=> state_reg == bq_pkg::ST_A1)
        else $error("accepted sample did not start the sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == bq_pkg::ST_IDLE)
        else $error("commit did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while output register still full");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.w_latch |=> state_reg == bq_pkg::ST_B2 && $past(cmd.acc_clear))
        else $error("intermediate latch out of sequence");

endmodule

[rtl/biquad_direct_form_2_filter.sv]
`timescale 1ns / 1ps
// ============================================================================
// Biquad direct form II filter
// Second-order IIR: w = x + a1*w1 + a2*w2, y = b0*w + b1*w1 + b2*w2, with
// rounded, saturated fixed point (Q1.23 samples, Q4.20 coefs, Q9.23 state).
// ============================================================================
//
//  Channel  Dir  Payload                  Request completes when
//  -------  ---  -----------------------  -----------------------------
//  din      in   sample_in  [23:0] s      din.valid && din.ready
//  dout     out  sample_out [23:0] s      dout.valid && dout.ready
//  cfg      in   index [2:0], data [23:0] cfg.valid && cfg.ready (always ready)
//
//  Sequence: a new sample is accepted only once the previous one is committed.
//  In between, the single shared 24x32 multiplier does five products, each
//  followed by a product register and an accumulate step, plus two
//  round/clamp steps.
//  Reset: rst_n clears coefficients, delay pair, controller and output valid.
//  Stalls: a new request is accepted while the previous result still waits
//  on dout; the controller holds in its final step only if the output
//  register is still full when the next result is ready.
//
module biquad_direct_form_2_filter (
    input  logic      clk,
    input  logic      rst_n,
    bq_in_if.sink     din,
    bq_out_if.source  dout,
    bq_cfg_if.sink    cfg
);

    bq_pkg::ctrl_cmd_t    cmd;
    bq_pkg::ctrl_status_t status;

    // Sequencer: walks feedback sum, rounding, feedforward sum, commit.
    bq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Arithmetic, state and output register.
    bq_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .din    (din),
        .dout   (dout),
        .cfg    (cfg)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Biquad direct form II filter testbench
// Drives samples and coefficient writes into the filter, and predicts every
// filtered sample with its own fixed point model. Directed cases first, then
// randomized coefficient settings with random stalls on both channels.
// ============================================================================
module tb;

    localparam logic signed [bq_pkg::COEF_W-1:0]   COEF_MAX   = 24'sh7FFFFF;
    localparam logic signed [bq_pkg::COEF_W-1:0]   COEF_MIN   = 24'sh800000;
    localparam logic signed [bq_pkg::COEF_W-1:0]   COEF_ONE   = 24'sh100000;  // 1.0 in Q4.20
    localparam logic signed [bq_pkg::COEF_W-1:0]   COEF_HALF  = 24'sh080000;  // 0.5 in Q4.20
    localparam logic signed [bq_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [bq_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam int NUM_COEFS    = int'(bq_pkg::REG_B2) + 1;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PERCENT = 19;

    logic clk;
    logic rst_n;

    bq_in_if  din_ch ();
    bq_out_if dout_ch ();
    bq_cfg_if cfg_ch ();

    biquad_direct_form_2_filter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // Filter model: coefficient bank and the delayed intermediate values
    // ------------------------------------------------------------------------
    logic signed [bq_pkg::COEF_W-1:0]   coef_bank [NUM_COEFS];
    logic signed [bq_pkg::STATE_W-1:0]  w_recent;
    logic signed [bq_pkg::STATE_W-1:0]  w_older;

    // Filtered samples still owed by the block, oldest first.
    logic signed [bq_pkg::SAMPLE_W-1:0] expected_samples [$];
    logic signed [bq_pkg::SAMPLE_W-1:0] next_expected;

    int          mismatch_count  = 0;
    int unsigned hold_off_cycles = 0;   // receiver blackout, counted below
    bit          no_idle         = 1'b0;

    // Round half up from 43 to 23 fraction bits, then clamp.
    function automatic longint round_clamp(input longint sum, input longint lo,
                                           input longint hi);
        longint r;
        r = (sum + (longint'(1) <<< (bq_pkg::FRAC_SHIFT - 1))) >>> bq_pkg::FRAC_SHIFT;
        if (r < lo)
            return lo;
        if (r > hi)
            return hi;
        return r;
    endfunction

    // Advance the model by one sample and return the filtered sample.
    function automatic logic signed [bq_pkg::SAMPLE_W-1:0] filter_step(
        input logic signed [bq_pkg::SAMPLE_W-1:0] x
    );
        longint sum;
        longint w;
        longint y;
        sum = (longint'(x) <<< bq_pkg::FRAC_SHIFT)
            + longint'(coef_bank[bq_pkg::REG_A1]) * longint'(w_recent)
            + longint'(coef_bank[bq_pkg::REG_A2]) * longint'(w_older);
        w = round_clamp(sum, -(longint'(1) <<< (bq_pkg::STATE_W - 1)),
                        (longint'(1) <<< (bq_pkg::STATE_W - 1)) - 1);
        sum = longint'(coef_bank[bq_pkg::REG_B0]) * w
            + longint'(coef_bank[bq_pkg::REG_B1]) * longint'(w_recent)
            + longint'(coef_bank[bq_pkg::REG_B2]) * longint'(w_older);
        y = round_clamp(sum, longint'(SAMPLE_MIN), longint'(SAMPLE_MAX));
        w_older  = w_recent;
        w_recent = bq_pkg::STATE_W'(w);
        return bq_pkg::SAMPLE_W'(y);
    endfunction

    // Uniform in [-bound, bound - 1].
    function automatic logic signed [bq_pkg::COEF_W-1:0] random_coef(input int bound);
        return bq_pkg::COEF_W'(int'($urandom_range(2 * bound - 1)) - bound);
    endfunction

    // Mostly full range, some small values near zero, some extremes.
    function automatic logic signed [bq_pkg::SAMPLE_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (pick < 25)
            return bq_pkg::SAMPLE_W'(int'($urandom_range(8191)) - 4096);
        return bq_pkg::SAMPLE_W'($urandom());
    endfunction

    // ------------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A run that reaches this limit reports mismatches and ends.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, a counted blackout on request, none in steady
    // stretches
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            dout_ch.ready <= 1'b0;
        else if (hold_off_cycles != 0)
        begin
            dout_ch.ready <= 1'b0;
            hold_off_cycles--;
        end
        else
            dout_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each filtered sample with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && dout_ch.valid && dout_ch.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%t: unexpected sample_out %0d, none pending", $realtime,
                             dout_ch.sample_out);
            end
            else
            begin
                next_expected = expected_samples.pop_front();
                if (dout_ch.sample_out !== next_expected)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%t: sample_out expected %0d got %0d", $realtime,
                                 next_expected, dout_ch.sample_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared driver tasks
    // ------------------------------------------------------------------------

    // Offer one sample, after an optional random gap; predict on acceptance.
    // Leave valid high so a back-to-back request needs no second assignment.
    task automatic send_sample(input logic signed [bq_pkg::SAMPLE_W-1:0] x);
        int unsigned gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 30)
            gap = $urandom_range(12, 1);
        repeat (gap)
        begin
            din_ch.valid <= 1'b0;
            @(posedge clk);
        end
        din_ch.valid     <= 1'b1;
        din_ch.sample_in <= x;
        do
        begin
            @(posedge clk);
        end
        while (!din_ch.ready);
        expected_samples.push_back(filter_step(x));
    endtask

    // Drop the sample request and hold until every filtered sample is back.
    task automatic wait_for_idle();
        din_ch.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    // One coefficient write request; out-of-range indexes leave the bank alone.
    task automatic write_coef(input logic [bq_pkg::IDX_W-1:0] idx,
                              input logic signed [bq_pkg::COEF_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        if (idx <= bq_pkg::REG_B2)
            coef_bank[idx] = value;
    endtask

    task automatic program_filter(
        input logic signed [bq_pkg::COEF_W-1:0] a1, a2, b0, b1, b2
    );
        wait_for_idle();
        write_coef(bq_pkg::REG_A1, a1);
        write_coef(bq_pkg::REG_A2, a2);
        write_coef(bq_pkg::REG_B0, b0);
        write_coef(bq_pkg::REG_B1, b1);
        write_coef(bq_pkg::REG_B2, b2);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All coefficients clear after reset: every output is zero.
    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'sh123456);
    endtask

    // b0 = 1.0 alone passes the input straight through.
    task automatic test_passthrough();
        program_filter('0, '0, COEF_ONE, '0, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
    endtask

    // b0 = 0.5 puts odd inputs exactly on the half LSB: ties round up.
    task automatic test_rounding();
        program_filter('0, '0, COEF_HALF, '0, '0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'sd3);
        send_sample(-24'sd3);
    endtask

    // Maximum gains drive the state and output into both clamps.
    task automatic test_saturation();
        program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        repeat (3)
            send_sample(SAMPLE_MAX);
        repeat (3)
            send_sample(SAMPLE_MIN);
    endtask

    // Writes to unused indexes must not disturb any coefficient.
    task automatic test_unused_index();
        program_filter(24'sh040000, -24'sh020000, COEF_ONE, 24'sh010000, -24'sh008000);
        send_sample(24'sh200000);
        send_sample(-24'sh100000);
        wait_for_idle();
        for (int idx = NUM_COEFS; idx < (1 << bq_pkg::IDX_W); idx++)
            write_coef(bq_pkg::IDX_W'(idx), COEF_MAX);
        cfg_ch.valid <= 1'b0;
        send_sample(24'sh300000);
        send_sample(SAMPLE_MIN);
        send_sample(24'sh0ABCDE);
    endtask

    // Cycle through stable, wide random and extreme coefficient settings.
    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                    // |a1| + |a2| < 1 keeps the recursion decaying.
                    program_filter(random_coef(1 << 19), random_coef(1 << 18),
                                   random_coef(1 << 21), random_coef(1 << 21),
                                   random_coef(1 << 21));
                1:
                    program_filter(random_coef(1 << 23), random_coef(1 << 23),
                                   random_coef(1 << 23), random_coef(1 << 23),
                                   random_coef(1 << 23));
                2:
                    program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
                default:
                    program_filter($urandom_range(1) ? COEF_MAX : COEF_MIN,
                                   $urandom_range(1) ? COEF_MAX : COEF_MIN,
                                   $urandom_range(1) ? COEF_MAX : COEF_MIN,
                                   $urandom_range(1) ? COEF_MAX : COEF_MIN,
                                   $urandom_range(1) ? COEF_MAX : COEF_MIN);
            endcase
            repeat (100)
                send_sample(random_sample());
        end
    endtask

    // Black out the receiver while samples keep coming, so the input stalls.
    task automatic test_back_pressure();
        program_filter(random_coef(1 << 19), random_coef(1 << 18), random_coef(1 << 21),
                       random_coef(1 << 21), random_coef(1 << 21));
        no_idle         = 1'b1;
        hold_off_cycles = 80;
        repeat (40)
            send_sample(random_sample());
        no_idle = 1'b0;
    endtask

    // Long stretch with neither side idling.
    task automatic test_steady_stream();
        program_filter(random_coef(1 << 19), random_coef(1 << 18), random_coef(1 << 21),
                       random_coef(1 << 21), random_coef(1 << 21));
        no_idle = 1'b1;
        repeat (150)
            send_sample(random_sample());
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        din_ch.valid     = 1'b0;
        din_ch.sample_in = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        dout_ch.ready    = 1'b0;
        for (int i = 0; i < NUM_COEFS; i++)
            coef_bank[i] = '0;
        w_recent = '0;
        w_older  = '0;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_passthrough();
        test_rounding();
        test_saturation();
        test_unused_index();
        test_random_settings();
        test_back_pressure();
        test_steady_stream();

        // Drain, then watch a little longer for stray results.
        wait_for_idle();
        repeat (20)
            @(posedge clk);

        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
